### rtl/bounded_queue_deque_priority_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded queue / deque / priority queue block
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_QUEUE_DEQUE_PRIORITY_ASSERT_SVH
`define BOUNDED_QUEUE_DEQUE_PRIORITY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BQDP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqdp assertion failed");

// next-cycle implication
`define BQDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqdp assertion failed");

`else

`define BQDP_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define BQDP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/bqdp_pkg.sv
// ----------------------------------------------------------------------------
// bqdp_pkg
// Shared constants, codes and sequencer states of the bounded queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package bqdp_pkg;

   localparam int DEFAULT_DEPTH       = 16;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int MODE_W      = 2;
   localparam int CAP_W       = 5;
   localparam int TAG_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   // queue_mode codes; code 3 runs as linear
   localparam logic [MODE_W-1:0] MODE_LINEAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RM_WAIT,
      ST_P_RD,
      ST_P_CHK,
      ST_P_LAST,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/bqdp_ram.sv
// ----------------------------------------------------------------------------
// bqdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bqdp_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/bounded_queue_deque_priority.sv
// Sequence: linear and deque inserts, overflow and underflow go EXEC then DONE; a
//   successful remove goes EXEC, RM_WAIT, DONE; a priority insert walks the store
//   from the front through P_RD and P_CHK for each entry held, then P_LAST and DONE.
// A new item is taken only in IDLE, once the last one's result has left DONE.
// Reset (synchronous, active high): empty store, head 0, linear mode, limit 16.
//   Store contents are not cleared; only data from occupied cells is ever used.
// ----------------------------------------------------------------------------
// bounded_queue_deque_priority
// Bounded store of tagged entries served as FIFO, deque or priority queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_queue_deque_priority_assert.svh"

module bounded_queue_deque_priority #(
   parameter int DEPTH       = bqdp_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = bqdp_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration writes
   input  wire logic                               csr_wr_en,
   input  wire logic [bqdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bqdp_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_command,
   input  wire logic                               req_at_rear,
   input  wire logic [bqdp_pkg::TAG_W-1:0]         req_item_priority,
   input  wire logic [bqdp_pkg::TAG_W-1:0]         req_item_kind,
   input  wire logic [VALUE_WIDTH-1:0]             req_item_value,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [bqdp_pkg::STATUS_W-1:0]           rsp_status,
   output logic [VALUE_WIDTH-1:0]                  rsp_removed_value,
   output logic [bqdp_pkg::TAG_W-1:0]              rsp_removed_kind,
   output logic [bqdp_pkg::TAG_W-1:0]              rsp_removed_priority,
   output logic [$clog2(DEPTH+1)-1:0]              rsp_fill_level
);

   import bqdp_pkg::*;

   localparam int AW    = $clog2(DEPTH);          // store address bits
   localparam int CNT_W = $clog2(DEPTH + 1);      // fill count bits
   localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int EW    = VALUE_WIDTH + 2 * TAG_W; // entry: {prio, kind, value}

   // ring slot of the entry at a given offset from the head
   function automatic logic [AW-1:0] slot(input logic [AW-1:0]    base,
                                          input logic [CNT_W-1:0] offset);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW + 1)'(offset);
      if (sum >= (AW + 1)'(DEPTH)) begin
         sum = sum - (AW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [AW-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;        // walk position in priority insert
   logic                 found_ff, found_in;    // insert point passed
   logic [EW-1:0]        carry_ff, carry_in;    // entry moving one slot back
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched item
   logic                 cmd_ff;
   logic                 rear_ff;
   logic [EW-1:0]        nc_ff;

   // staged result
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [VALUE_WIDTH-1:0] res_value_ff, res_value_in;
   logic [TAG_W-1:0]       res_kind_ff, res_kind_in;
   logic [TAG_W-1:0]       res_prio_ff, res_prio_in;

   // output register
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [TAG_W-1:0]       rsp_kind_ff;
   logic [TAG_W-1:0]       rsp_prio_ff;
   logic [CNT_W-1:0]       rsp_fill_ff;
   logic                   load_rsp;

   // RAM port
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr;
   logic [EW-1:0]        rd_data;

   bqdp_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------------
   // Derived control
   // ------------------------------------------------------------------------
   logic              is_prio, is_deque;
   logic [LW-1:0]     limit;
   logic              full;
   logic [AW-1:0]     head_dec, head_inc;
   logic [AW-1:0]     slot_idx, slot_fill, slot_last;
   logic [CNT_W-1:0]  idx_next;
   logic              req_accept;

   // mode code 3 falls through to linear
   assign is_prio  = (mode_ff == MODE_PRIORITY);
   assign is_deque = (mode_ff == MODE_DEQUE);

   // effective limit is capacity_limit clipped at the store depth
   assign limit = (LW'(cap_ff) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_ff);
   assign full  = (LW'(fill_ff) >= limit);

   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   assign slot_idx  = slot(head_ff, idx_ff);
   assign slot_fill = slot(head_ff, fill_ff);
   assign slot_last = slot(head_ff, fill_ff - CNT_W'(1));
   assign idx_next  = idx_ff + CNT_W'(1);

   // one item at a time: take a new one only when the sequencer is idle
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      carry_in      = carry_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_kind_in   = res_kind_ff;
      res_prio_in   = res_prio_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      load_rsp      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_fill;
      wr_data       = carry_ff;
      rd_addr       = slot_idx;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_status_in = STATUS_OK;
            res_value_in  = '0;
            res_kind_in   = '0;
            res_prio_in   = '0;
            // remove reads the front, or the rear entry in deque rear mode
            rd_addr = rear_ff ? slot_last : head_ff;
            if (cmd_ff == CMD_INSERT) begin
               if (full) begin
                  res_status_in = STATUS_OVERFLOW;
                  state_in      = ST_DONE;
               end else if (is_prio) begin
                  // walk from the front, shifting everything behind the insert point
                  idx_in   = '0;
                  found_in = 1'b0;
                  carry_in = nc_ff;
                  state_in = (fill_ff == '0) ? ST_P_LAST : ST_P_RD;
               end else if (is_deque && !rear_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  wr_data  = nc_ff;
                  head_in  = head_dec;
                  fill_in  = fill_ff + CNT_W'(1);
                  state_in = ST_DONE;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot_fill;
                  wr_data  = nc_ff;
                  fill_in  = fill_ff + CNT_W'(1);
                  state_in = ST_DONE;
               end
            end else begin
               if (fill_ff == '0) begin
                  res_status_in = STATUS_UNDERFLOW;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_RM_WAIT;
               end
            end
         end

         ST_RM_WAIT: begin
            res_prio_in  = rd_data[EW-1 -: TAG_W];
            res_kind_in  = rd_data[VALUE_WIDTH +: TAG_W];
            res_value_in = rd_data[VALUE_WIDTH-1:0];
            if (!rear_ff) begin
               head_in = head_inc;
            end
            fill_in  = fill_ff - CNT_W'(1);
            state_in = ST_DONE;
         end

         ST_P_RD: begin
            state_in = ST_P_CHK;
         end

         ST_P_CHK: begin
            // first strictly lower priority marks the insert point
            if (found_ff || (rd_data[EW-1 -: TAG_W] < nc_ff[EW-1 -: TAG_W])) begin
               wr_en    = 1'b1;
               wr_addr  = slot_idx;
               wr_data  = carry_ff;
               carry_in = rd_data;
               found_in = 1'b1;
            end
            idx_in   = idx_next;
            state_in = (idx_next == fill_ff) ? ST_P_LAST : ST_P_RD;
         end

         ST_P_LAST: begin
            // last displaced entry, or the new one, lands at the rear
            wr_en    = 1'b1;
            wr_addr  = slot_fill;
            wr_data  = carry_ff;
            fill_in  = fill_ff + CNT_W'(1);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LINEAR;
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_QUEUE_MODE: mode_ff <= csr_wr_data[MODE_W-1:0];
               CSR_CAPACITY:   cap_ff  <= csr_wr_data[CAP_W-1:0];
               default: begin
               end
            endcase
         end
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      carry_ff      <= carry_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_kind_ff   <= res_kind_in;
      res_prio_ff   <= res_prio_in;
      if (req_accept) begin
         cmd_ff  <= req_command;
         rear_ff <= is_deque && req_at_rear;
         nc_ff   <= {req_item_priority, req_item_kind, req_item_value};
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_kind_ff   <= res_kind_ff;
         rsp_prio_ff   <= res_prio_ff;
         rsp_fill_ff   <= fill_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_value    = rsp_value_ff;
   assign rsp_removed_kind     = rsp_kind_ff;
   assign rsp_removed_priority = rsp_prio_ff;
   assign rsp_fill_level       = rsp_fill_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `BQDP_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(DEPTH))
   `BQDP_ASSERT_IMPL(a_ovf_only_full, clock, reset,
      (state_ff == ST_DONE) && (res_status_ff == STATUS_OVERFLOW), full)
   `BQDP_ASSERT_IMPL(a_udf_only_empty, clock, reset,
      (state_ff == ST_DONE) && (res_status_ff == STATUS_UNDERFLOW), fill_ff == '0)
   `BQDP_ASSERT_NEXT(a_rsp_after_done, clock, reset,
      !rsp_valid_ff && (state_ff != ST_DONE), !rsp_valid_ff)

endmodule

`default_nettype wire

### tb/tb_bounded_queue_deque_priority.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_queue_deque_priority
// Self-checking bench for the bounded FIFO / deque / priority queue. A short
// scripted sequence hits each mode, the limits and the odd tag values. Random
// traffic follows under a series of mode and limit settings. Every result is
// compared field by field against a behavioral copy of the store or a written-out result.
// ----------------------------------------------------------------------------

module tb_bounded_queue_deque_priority;
   import bqdp_pkg::*;

   localparam int DEPTH  = DEFAULT_DEPTH;
   localparam int VW     = DEFAULT_VALUE_WIDTH;
   localparam int FILL_W = $clog2(DEPTH + 1);

   // mode code 3 has no name in the package; the block runs it as linear
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam logic [TAG_W-1:0] PRIO_LOW  = 2'd0;
   localparam logic [TAG_W-1:0] PRIO_MED  = 2'd1;
   localparam logic [TAG_W-1:0] PRIO_HIGH = 2'd2;
   localparam logic [TAG_W-1:0] PRIO_TOP  = 2'd3;   // out of range, ranks above high
   localparam logic [TAG_W-1:0] KIND_INT  = 2'd0;
   localparam logic [TAG_W-1:0] KIND_REAL = 2'd1;
   localparam logic [TAG_W-1:0] KIND_CHAR = 2'd2;
   localparam logic [TAG_W-1:0] KIND_ODD  = 2'd3;   // out of range, stored as is

   // random phases: mode, limit and item count for each
   localparam int PHASES = 8;
   localparam int QUIET_PHASE = 2;                   // no idling on either side here

   typedef struct packed {
      logic             cmd;
      logic             rear;
      logic [TAG_W-1:0] prio;
      logic [TAG_W-1:0] kind;
      logic [VW-1:0]    value;
   } op_type;

   typedef struct packed {
      logic [VW-1:0]    value;
      logic [TAG_W-1:0] kind;
      logic [TAG_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VW-1:0]       value;
      logic [TAG_W-1:0]    kind;
      logic [TAG_W-1:0]    prio;
      logic [FILL_W-1:0]   fill;
   } result_type;

   // one line of the scripted sequence: either a register write or an item
   typedef struct {
      bit                     cfg;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      op_type                 op;
      bit                     typed;     // want holds a hand-written result
      result_type             want;
   } script_row_type;

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_command = CMD_INSERT;
   logic                   req_at_rear = 1'b0;
   logic [TAG_W-1:0]       req_item_priority = '0;
   logic [TAG_W-1:0]       req_item_kind = '0;
   logic [VW-1:0]          req_item_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [VW-1:0]          rsp_removed_value;
   logic [TAG_W-1:0]       rsp_removed_kind;
   logic [TAG_W-1:0]       rsp_removed_priority;
   logic [FILL_W-1:0]      rsp_fill_level;

   bounded_queue_deque_priority uut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_at_rear         (req_at_rear),
      .req_item_priority   (req_item_priority),
      .req_item_kind       (req_item_kind),
      .req_item_value      (req_item_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_removed_value   (rsp_removed_value),
      .rsp_removed_kind    (rsp_removed_kind),
      .rsp_removed_priority(rsp_removed_priority),
      .rsp_fill_level      (rsp_fill_level)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Behavioral copy of the store: ring of cells, head, fill, registers
   // ------------------------------------------------------------------------
   entry_type         ring [DEPTH];
   int                ring_head = 0;
   int                ring_fill = 0;
   logic [MODE_W-1:0] cfg_mode  = MODE_LINEAR;
   logic [CAP_W-1:0]  cfg_limit = CAP_RESET;

   result_type        pending_results [$];   // in result order
   script_row_type    script [$];
   int                mismatches = 0;
   int                results_seen = 0;
   bit                idle_on = 1'b1;

   logic [MODE_W-1:0] plan_mode  [PHASES] = '{MODE_LINEAR, MODE_DEQUE, MODE_PRIORITY,
                                              MODE_DEQUE, MODE_LINEAR, MODE_PRIORITY,
                                              MODE_SPARE, MODE_PRIORITY};
   // 31 runs above the depth; 0 follows it so a full store gets drained under
   // a zero limit
   logic [CAP_W-1:0]  plan_limit [PHASES] = '{5'd16, 5'd16, 5'd16, 5'd31,
                                              5'd0, 5'd4, 5'd1, 5'd16};
   int                plan_len   [PHASES] = '{70, 70, 80, 70, 30, 60, 50, 70};

   // Applies one item to the copy of the store and returns its result.
   function automatic result_type queue_apply(input op_type op);
      result_type        r;
      entry_type         e;
      logic [MODE_W-1:0] m;
      bit                rear;
      int                lim;
      int                pos;
      int                i;
      r    = '0;
      m    = (cfg_mode == MODE_SPARE) ? MODE_LINEAR : cfg_mode;
      rear = (m == MODE_DEQUE) && op.rear;
      lim  = (cfg_limit < DEPTH) ? cfg_limit : DEPTH;
      e    = '{value: op.value, kind: op.kind, prio: op.prio};
      if (op.cmd == CMD_INSERT) begin
         if (ring_fill >= lim) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            if (m == MODE_PRIORITY) begin
               // goes ahead of the first strictly lower priority; nothing is resorted
               pos = 0;
               while (pos < ring_fill && ring[(ring_head + pos) % DEPTH].prio >= e.prio)
                  pos++;
               for (i = ring_fill; i > pos; i--)
                  ring[(ring_head + i) % DEPTH] = ring[(ring_head + i - 1) % DEPTH];
               ring[(ring_head + pos) % DEPTH] = e;
            end else if (m == MODE_DEQUE && !rear) begin
               ring_head = (ring_head + DEPTH - 1) % DEPTH;
               ring[ring_head] = e;
            end else begin
               ring[(ring_head + ring_fill) % DEPTH] = e;
            end
            ring_fill++;
            r.status = STATUS_OK;
         end
      end else if (ring_fill == 0) begin
         r.status = STATUS_UNDERFLOW;
      end else begin
         if (rear) begin
            e = ring[(ring_head + ring_fill - 1) % DEPTH];
         end else begin
            e = ring[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
         end
         ring_fill--;
         r.status = STATUS_OK;
         r.value  = e.value;
         r.kind   = e.kind;
         r.prio   = e.prio;
      end
      r.fill = FILL_W'(ring_fill);
      return r;
   endfunction

   function automatic void script_cfg(input logic [CSR_INDEX_W-1:0] idx,
                                      input logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row = '{cfg: 1'b1, reg_idx: idx, reg_val: val, op: '0, typed: 1'b0, want: '0};
      script.push_back(row);
   endfunction

   // want_fill < 0: checked against the copy of the store; otherwise the result
   // is status plus fill, with the removed fields zero
   function automatic void script_op(input logic cmd, input logic rear,
                                     input logic [TAG_W-1:0] prio,
                                     input logic [TAG_W-1:0] kind,
                                     input logic [VW-1:0] value,
                                     input int want_fill = -1,
                                     input logic [STATUS_W-1:0] want_status = STATUS_OK);
      script_row_type row;
      row = '{cfg: 1'b0, reg_idx: '0, reg_val: '0, op: '0, typed: 1'b0, want: '0};
      row.op = '{cmd: cmd, rear: rear, prio: prio, kind: kind, value: value};
      if (want_fill >= 0) begin
         row.typed       = 1'b1;
         row.want.status = want_status;
         row.want.fill   = FILL_W'(want_fill);
      end
      script.push_back(row);
   endfunction

   task automatic flag_mismatch(input string what, input logic [VW-1:0] got,
                                input logic [VW-1:0] want);
      $display("[%0t] result %0d: %s got %0h, want %0h", $time, results_seen, what,
               got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Driving: all at the falling edge. Entered and left at a falling edge;
   // valid is left high so back-to-back items need a single assignment.
   // ------------------------------------------------------------------------
   task automatic send_op(input op_type op, input bit typed, input result_type want);
      result_type got;
      while (idle_on && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= op.cmd;
      req_at_rear       <= op.rear;
      req_item_priority <= op.prio;
      req_item_kind     <= op.kind;
      req_item_value    <= op.value;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = queue_apply(op);
      pending_results.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   // Drop valid and wait until every result is back, then let the clock run idle.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_QUEUE_MODE)
         cfg_mode = val[MODE_W-1:0];
      else
         cfg_limit = val[CAP_W-1:0];
      @(negedge clock);
   endtask

   // result side back-pressure, off during the quiet phase
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 37);
   end

   // ------------------------------------------------------------------------
   // Result check, sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      result_type w;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_mismatch("unexpected result, status", VW'(rsp_status), '0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_status !== w.status)
               flag_mismatch("status", VW'(rsp_status), VW'(w.status));
            if (rsp_removed_value !== w.value)
               flag_mismatch("removed_value", rsp_removed_value, w.value);
            if (rsp_removed_kind !== w.kind)
               flag_mismatch("removed_kind", VW'(rsp_removed_kind), VW'(w.kind));
            if (rsp_removed_priority !== w.prio)
               flag_mismatch("removed_priority", VW'(rsp_removed_priority), VW'(w.prio));
            if (rsp_fill_level !== w.fill)
               flag_mismatch("fill_level", VW'(rsp_fill_level), VW'(w.fill));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      op_type         op;
      script_row_type row;
      int             p;
      int             n;
      int             bias;

      // --- scripted part; reset state is linear mode, limit 16 ---
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0, 0, STATUS_UNDERFLOW);
      script_op(CMD_INSERT, 1'b0, PRIO_LOW, KIND_INT, 32'h0000_0000, 1);
      // out-of-range tags come back unchanged
      script_op(CMD_INSERT, 1'b1, PRIO_TOP, KIND_ODD, 32'hFFFF_FFFF, 2);
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b1, PRIO_HIGH, KIND_CHAR, 32'hFFFF_FFFF);
      // zero limit: every insert overflows
      script_cfg(CSR_CAPACITY, 5'd0);
      script_op(CMD_INSERT, 1'b0, PRIO_MED, KIND_REAL, 32'h1234_5678, 0, STATUS_OVERFLOW);
      // deque, limit above the depth; rear removal must pull the rear back
      script_cfg(CSR_CAPACITY, 5'd31);
      script_cfg(CSR_QUEUE_MODE, CSR_DATA_W'(MODE_DEQUE));
      script_op(CMD_INSERT, 1'b0, PRIO_MED, KIND_REAL, 32'h1111_1111, 1);
      script_op(CMD_INSERT, 1'b1, PRIO_HIGH, KIND_CHAR, 32'h2222_2222, 2);
      script_op(CMD_INSERT, 1'b0, PRIO_LOW, KIND_INT, 32'h3333_3333, 3);
      script_op(CMD_REMOVE, 1'b1, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b1, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b1, PRIO_LOW, KIND_INT, 32'h0, 0, STATUS_UNDERFLOW);
      // priority order, FIFO among equals, overflow at a small limit
      script_cfg(CSR_QUEUE_MODE, CSR_DATA_W'(MODE_PRIORITY));
      script_cfg(CSR_CAPACITY, 5'd3);
      script_op(CMD_INSERT, 1'b0, PRIO_LOW, KIND_INT, 32'hA5A5_A5A5, 1);
      script_op(CMD_INSERT, 1'b1, PRIO_HIGH, KIND_REAL, 32'h5A5A_5A5A, 2);
      script_op(CMD_INSERT, 1'b0, PRIO_HIGH, KIND_CHAR, 32'h8000_0001, 3);
      script_op(CMD_INSERT, 1'b0, PRIO_MED, KIND_INT, 32'h7FFF_FFFE, 3, STATUS_OVERFLOW);
      script_op(CMD_REMOVE, 1'b1, PRIO_LOW, KIND_INT, 32'h0);
      // spare mode code appends like linear, leaving the order unsorted
      script_cfg(CSR_QUEUE_MODE, CSR_DATA_W'(MODE_SPARE));
      script_op(CMD_INSERT, 1'b1, PRIO_TOP, KIND_ODD, 32'hDEAD_BEEF, 3);
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0);
      // back to priority with unsorted entries held
      script_cfg(CSR_QUEUE_MODE, CSR_DATA_W'(MODE_PRIORITY));
      script_op(CMD_INSERT, 1'b0, PRIO_MED, KIND_REAL, 32'h0F0F_0F0F);
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b1, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0);
      script_op(CMD_REMOVE, 1'b0, PRIO_LOW, KIND_INT, 32'h0, 0, STATUS_UNDERFLOW);

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.cfg) begin
            settle();
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            send_op(row.op, row.typed, row.want);
         end
      end

      // --- random part: registers change only with nothing in flight ---
      for (p = 0; p < PHASES; p++) begin
         settle();
         write_reg(CSR_QUEUE_MODE, CSR_DATA_W'(plan_mode[p]));
         write_reg(CSR_CAPACITY, plan_limit[p]);
         idle_on = (p != QUIET_PHASE);
         for (n = 0; n < plan_len[p]; n++) begin
            // bursts lean to insert, then to remove, so full and empty both occur
            bias = ((n / 20) % 2 == 0) ? 75 : 30;
            op.cmd  = ($urandom_range(99) < bias) ? CMD_INSERT : CMD_REMOVE;
            op.rear = 1'($urandom_range(1));
            op.prio = ($urandom_range(9) == 0) ? PRIO_TOP : TAG_W'($urandom_range(2));
            op.kind = TAG_W'($urandom_range(3));
            case ($urandom_range(7))
               0: begin
                  op.value = '0;
               end
               1: begin
                  op.value = '1;
               end
               default: begin
                  op.value = $urandom();
               end
            endcase
            send_op(op, 1'b0, '0);
         end
      end

      settle();
      idle_on = 1'b0;
      repeat (40) @(posedge clock);   // room for the longest priority insert
      if (mismatches == 0)
         $display("bounded_queue_deque_priority verification clean");
      else
         $display("bounded_queue_deque_priority verification failed");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("bounded_queue_deque_priority verification failed");
      $finish;
   end

endmodule

### bounded_queue_deque_priority.f
+incdir+rtl
rtl/bqdp_pkg.sv
rtl/bqdp_ram.sv
rtl/bounded_queue_deque_priority.sv
tb/tb_bounded_queue_deque_priority.sv
